>>> rtl/dpc_pkg.sv
`default_nettype none

package dpc_pkg;

   // Fixed field widths
   localparam int Q_W      = 32;
   localparam int SIZE_W   = 13;
   localparam int COLOUR_W = 24;
   localparam int CSR_IDX_W = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_DISTANCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_DISTANCE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_FOCAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOUD_ENABLE  = 3'd5;

   // Register reset values
   localparam logic [Q_W-1:0]    NEAR_RESET    = 32'd655;
   localparam logic [Q_W-1:0]    FAR_RESET     = 32'd3276800;
   localparam logic [Q_W-1:0]    INVF_RESET    = 32'd7412700;
   localparam logic [SIZE_W-1:0] WIDTH_RESET   = 13'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET  = 13'd480;

   // Status of one transaction between the depth front end and the divider
   typedef struct packed {
      logic in_range;
      logic overflow;
      logic den_zero;
   } dpc_flags_type;

endpackage

`default_nettype wire

>>> rtl/dpc_front.sv
`default_nettype none

module dpc_front
   import dpc_pkg::*;
#(
   parameter int DEPTH_FRAC_BITS = 24,
   parameter int META_W = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [Q_W-1:0]              near_distance,
   input  logic [Q_W-1:0]              far_distance,
   input  logic                        in_valid,
   input  logic [DEPTH_FRAC_BITS-1:0]  in_raw,
   input  logic [META_W-1:0]           in_meta,
   output logic                        out_valid,
   output dpc_flags_type               out_flags,
   output logic [DEPTH_FRAC_BITS+32:0] out_den,
   output logic [DEPTH_FRAC_BITS+31:0] out_rem,
   output logic [Q_W-1:0]              out_low,
   output logic [META_W-1:0]           out_meta
);

   localparam int F     = DEPTH_FRAC_BITS;
   localparam int DEN_W = F + 33;
   localparam logic [F:0] ONE_DEPTH = {1'b1, {F{1'b0}}};
   localparam logic [F:0] FAR_LIMIT = (F+1)'(ONE_DEPTH - ONE_DEPTH / 1000000);

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic              s1_in_range_ff, s2_in_range_ff;
   logic [63:0]       s1_prod_ff, s2_prod_ff;
   logic [DEN_W-1:0]  s1_far_part_ff, s2_den_ff;
   logic [F+31:0]     s1_near_part_ff;
   logic [META_W-1:0] s1_meta_ff, s2_meta_ff, s3_meta_ff;
   dpc_flags_type     s3_flags_ff, s3_flags_in;
   logic [DEN_W-1:0]  s3_den_ff;
   logic [F+31:0]     s3_rem_ff;
   logic [Q_W-1:0]    s3_low_ff;
   logic [63+F:0]     dividend;

   // Stage 1: the three products
   always_ff @(posedge clock) begin
      s1_prod_ff      <= 64'(near_distance) * 64'(far_distance);
      s1_far_part_ff  <= DEN_W'(far_distance) * DEN_W'(ONE_DEPTH - {1'b0, in_raw});
      s1_near_part_ff <= (F+32)'(in_raw) * (F+32)'(near_distance);
      s1_in_range_ff  <= {1'b0, in_raw} < FAR_LIMIT;
      s1_meta_ff      <= in_meta;
   end

   // Stage 2: denominator
   always_ff @(posedge clock) begin
      s2_den_ff      <= s1_far_part_ff + DEN_W'(s1_near_part_ff);
      s2_prod_ff     <= s1_prod_ff;
      s2_in_range_ff <= s1_in_range_ff;
      s2_meta_ff     <= s1_meta_ff;
   end

   // Stage 3: overflow check and initial remainder
   assign dividend = {s2_prod_ff, {F{1'b0}}};

   always_comb begin
      s3_flags_in.in_range = s2_in_range_ff;
      s3_flags_in.overflow = {1'b0, dividend} >= {s2_den_ff, 32'b0};
      s3_flags_in.den_zero = s2_den_ff == '0;
   end

   always_ff @(posedge clock) begin
      s3_flags_ff <= s3_flags_in;
      s3_den_ff   <= s2_den_ff;
      s3_rem_ff   <= dividend[63+F:32];
      s3_low_ff   <= dividend[31:0];
      s3_meta_ff  <= s2_meta_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_flags = s3_flags_ff;
   assign out_den   = s3_den_ff;
   assign out_rem   = s3_rem_ff;
   assign out_low   = s3_low_ff;
   assign out_meta  = s3_meta_ff;

endmodule

`default_nettype wire

>>> rtl/dpc_divider.sv
`default_nettype none

module dpc_divider
   import dpc_pkg::*;
#(
   parameter int DEN_W = 57,
   parameter int META_W = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  dpc_flags_type     in_flags,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [DEN_W-2:0]  in_rem,
   input  logic [Q_W-1:0]    in_low,
   input  logic [META_W-1:0] in_meta,
   output logic              out_valid,
   output dpc_flags_type     out_flags,
   output logic [Q_W-1:0]    out_quot,
   output logic [META_W-1:0] out_meta
);

   logic              valid_ff [Q_W];
   dpc_flags_type     flags_ff [Q_W];
   logic [DEN_W-1:0]  den_ff   [Q_W];
   logic [DEN_W-1:0]  rem_ff   [Q_W];
   logic [Q_W-1:0]    low_ff   [Q_W];
   logic [Q_W-1:0]    quot_ff  [Q_W];
   logic [META_W-1:0] meta_ff  [Q_W];

   // One restoring step per stage, most significant quotient bit first
   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic              src_valid;
      dpc_flags_type     src_flags;
      logic [DEN_W-1:0]  src_den, src_rem, rem_in;
      logic [Q_W-1:0]    src_low, src_quot;
      logic [META_W-1:0] src_meta;
      logic [DEN_W:0]    rem_shift;
      logic              take;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_flags = in_flags;
         assign src_den   = in_den;
         assign src_rem   = {1'b0, in_rem};
         assign src_low   = in_low;
         assign src_quot  = '0;
         assign src_meta  = in_meta;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_flags = flags_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_low   = low_ff[k-1];
         assign src_quot  = quot_ff[k-1];
         assign src_meta  = meta_ff[k-1];
      end

      // Shift in the next dividend bit, subtract when it fits
      assign rem_shift = {src_rem, src_low[Q_W-1]};
      assign take      = rem_shift >= {1'b0, src_den};
      assign rem_in    = take ? DEN_W'(rem_shift - {1'b0, src_den}) : rem_shift[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         flags_ff[k] <= src_flags;
         den_ff[k]   <= src_den;
         rem_ff[k]   <= rem_in;
         low_ff[k]   <= {src_low[Q_W-2:0], 1'b0};
         quot_ff[k]  <= {src_quot[Q_W-2:0], take};
         meta_ff[k]  <= src_meta;
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_flags = flags_ff[Q_W-1];
   assign out_quot  = quot_ff[Q_W-1];
   assign out_meta  = meta_ff[Q_W-1];

endmodule

`default_nettype wire

>>> rtl/dpc_project.sv
`default_nettype none

module dpc_project
   import dpc_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [Q_W-1:0]                  inverse_focal,
   input  logic [SIZE_W-1:0]               image_width,
   input  logic [SIZE_W-1:0]               image_height,
   input  logic                            cloud_enable,
   input  logic                            in_valid,
   input  dpc_flags_type                   in_flags,
   input  logic [Q_W-1:0]                  in_quot,
   input  logic [COLOUR_W+2*COORD_BITS-1:0] in_meta,
   output logic                            rsp_valid,
   output logic [Q_W-1:0]                  rsp_depth_metres,
   output logic                            rsp_depth_valid,
   output logic signed [Q_W-1:0]           rsp_point_x,
   output logic signed [Q_W-1:0]           rsp_point_y,
   output logic [Q_W-1:0]                  rsp_point_z,
   output logic [COLOUR_W-1:0]             rsp_packed_colour,
   output logic                            rsp_point_valid,
   output logic [COORD_BITS-1:0]           rsp_out_row,
   output logic [COORD_BITS-1:0]           rsp_out_column
);

   localparam int CB    = COORD_BITS;
   localparam int MAG_W = (CB + 1 > SIZE_W) ? CB + 1 : SIZE_W;
   localparam int PRD_W = 64 + MAG_W;

   // Sign and magnitude of (2*pos - size)
   function automatic logic [MAG_W:0] centre_offset(input logic [CB-1:0] pos,
                                                    input logic [SIZE_W-1:0] size);
      logic [MAG_W-1:0] twice, sz;
      twice = MAG_W'({pos, 1'b0});
      sz    = MAG_W'(size);
      if (twice < sz) begin
         return {1'b1, MAG_W'(sz - twice)};
      end
      return {1'b0, MAG_W'(twice - sz)};
   endfunction

   // Scale down by 2^33, truncate toward zero and saturate to signed Q16.16
   function automatic logic [Q_W-1:0] to_q16(input logic neg, input logic [PRD_W-1:0] prod);
      logic [PRD_W-34:0] res;
      res = prod[PRD_W-1:33];
      if (neg) begin
         if (res > (PRD_W-33)'(33'h080000000)) begin
            return 32'h80000000;
         end
         return 32'd0 - res[Q_W-1:0];
      end
      if (res > (PRD_W-33)'(33'h07FFFFFFF)) begin
         return 32'h7FFFFFFF;
      end
      return res[Q_W-1:0];
   endfunction

   logic                p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic [Q_W-1:0]      p1_depth_in, p1_depth_ff, p2_depth_ff;
   logic                p1_pvalid_in, p1_pvalid_ff, p2_pvalid_ff;
   logic                p1_dvalid_ff, p2_dvalid_ff;
   logic [63:0]         p1_zf_ff;
   logic [MAG_W:0]      p1_off_x_ff, p1_off_y_ff;
   logic                p2_neg_x_ff, p2_neg_y_ff;
   logic [PRD_W-1:0]    p2_px_ff, p2_py_ff;
   logic [COLOUR_W-1:0] p1_colour_ff, p2_colour_ff;
   logic [CB-1:0]       p1_col_ff, p2_col_ff, p1_row_ff, p2_row_ff;
   logic [COLOUR_W-1:0] meta_colour;
   logic [CB-1:0]       meta_col, meta_row;

   logic [Q_W-1:0]      p3_depth_ff, p3_x_ff, p3_y_ff, p3_z_ff;
   logic                p3_dvalid_ff, p3_pvalid_ff;
   logic [COLOUR_W-1:0] p3_colour_ff;
   logic [CB-1:0]       p3_row_ff, p3_col_ff;

   assign meta_colour = in_meta[COLOUR_W+2*CB-1:2*CB];
   assign meta_col    = in_meta[2*CB-1:CB];
   assign meta_row    = in_meta[CB-1:0];

   // P1: resolve depth special cases
   always_comb begin
      priority if (!in_flags.in_range || in_flags.den_zero) begin
         p1_depth_in = '0;
      end else if (in_flags.overflow) begin
         p1_depth_in = '1;
      end else begin
         p1_depth_in = in_quot;
      end
      p1_pvalid_in = cloud_enable && in_flags.in_range && (p1_depth_in != '0);
   end

   always_ff @(posedge clock) begin
      p1_depth_ff  <= p1_depth_in;
      p1_pvalid_ff <= p1_pvalid_in;
      p1_dvalid_ff <= in_flags.in_range;
      p1_zf_ff     <= 64'(p1_depth_in) * 64'(inverse_focal);
      p1_off_x_ff  <= centre_offset(meta_col, image_width);
      p1_off_y_ff  <= centre_offset(meta_row, image_height);
      p1_colour_ff <= meta_colour;
      p1_col_ff    <= meta_col;
      p1_row_ff    <= meta_row;
   end

   // P2: scale by the offset from centre
   always_ff @(posedge clock) begin
      p2_px_ff     <= PRD_W'(p1_zf_ff) * PRD_W'(p1_off_x_ff[MAG_W-1:0]);
      p2_py_ff     <= PRD_W'(p1_zf_ff) * PRD_W'(p1_off_y_ff[MAG_W-1:0]);
      p2_neg_x_ff  <= p1_off_x_ff[MAG_W];
      p2_neg_y_ff  <= p1_off_y_ff[MAG_W];
      p2_depth_ff  <= p1_depth_ff;
      p2_pvalid_ff <= p1_pvalid_ff;
      p2_dvalid_ff <= p1_dvalid_ff;
      p2_colour_ff <= p1_colour_ff;
      p2_col_ff    <= p1_col_ff;
      p2_row_ff    <= p1_row_ff;
   end

   // P3: saturate and zero the point fields of invalid points
   always_ff @(posedge clock) begin
      p3_depth_ff  <= p2_depth_ff;
      p3_dvalid_ff <= p2_dvalid_ff;
      p3_pvalid_ff <= p2_pvalid_ff;
      p3_x_ff      <= p2_pvalid_ff ? to_q16(p2_neg_x_ff, p2_px_ff) : '0;
      p3_y_ff      <= p2_pvalid_ff ? to_q16(p2_neg_y_ff, p2_py_ff) : '0;
      p3_z_ff      <= p2_pvalid_ff ? p2_depth_ff : '0;
      p3_colour_ff <= p2_pvalid_ff ? p2_colour_ff : '0;
      p3_row_ff    <= p2_row_ff;
      p3_col_ff    <= p2_col_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   assign rsp_valid         = p3_valid_ff;
   assign rsp_depth_metres  = p3_depth_ff;
   assign rsp_depth_valid   = p3_dvalid_ff;
   assign rsp_point_x       = p3_x_ff;
   assign rsp_point_y       = p3_y_ff;
   assign rsp_point_z       = p3_z_ff;
   assign rsp_packed_colour = p3_colour_ff;
   assign rsp_point_valid   = p3_pvalid_ff;
   assign rsp_out_row       = p3_row_ff;
   assign rsp_out_column    = p3_col_ff;

endmodule

`default_nettype wire

>>> rtl/depth_to_point_cloud.sv
// Channel   | Handshake                 | Payload
// request   | start / busy              | req_depth_raw, req_red/green/blue, req_column,
//           |                           | req_row_from_bottom
// response  | rsp_valid (one cycle)     | rsp_depth_metres ... rsp_out_column
// csr       | csr_write_enable          | csr_index, csr_write_data
//
// One pixel is taken every clock while busy is low. The pipeline is the 32-stage restoring
// divider (one quotient bit per stage) plus three front stages (products, denominator,
// overflow) and three projection stages. Reset clears the valid bits and loads the register
// defaults; busy is high during reset and in the cycle after it. The receiver cannot stall,
// so the pipeline never holds.
`default_nettype none

module depth_to_point_cloud
   import dpc_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int DEPTH_FRAC_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [DEPTH_FRAC_BITS-1:0]   req_depth_raw,
   input  logic [7:0]                   req_red,
   input  logic [7:0]                   req_green,
   input  logic [7:0]                   req_blue,
   input  logic [COORD_BITS-1:0]        req_column,
   input  logic [COORD_BITS-1:0]        req_row_from_bottom,
   input  logic                         csr_write_enable,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [Q_W-1:0]               csr_write_data,
   output logic                         rsp_valid,
   output logic [Q_W-1:0]               rsp_depth_metres,
   output logic                         rsp_depth_valid,
   output logic signed [Q_W-1:0]        rsp_point_x,
   output logic signed [Q_W-1:0]        rsp_point_y,
   output logic [Q_W-1:0]               rsp_point_z,
   output logic [COLOUR_W-1:0]          rsp_packed_colour,
   output logic                         rsp_point_valid,
   output logic [COORD_BITS-1:0]        rsp_out_row,
   output logic [COORD_BITS-1:0]        rsp_out_column
);

   localparam int F      = DEPTH_FRAC_BITS;
   localparam int DEN_W  = F + 33;
   localparam int META_W = COLOUR_W + 2 * COORD_BITS;

   logic [Q_W-1:0]    near_ff, far_ff, invf_ff;
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic              enable_ff, busy_ff;
   logic              accept;
   logic [31:0]       row_wide;
   logic [META_W-1:0] req_meta;

   logic              fr_valid, dv_valid;
   dpc_flags_type     fr_flags, dv_flags;
   logic [DEN_W-1:0]  fr_den;
   logic [F+31:0]     fr_rem;
   logic [Q_W-1:0]    fr_low, dv_quot;
   logic [META_W-1:0] fr_meta, dv_meta;

   // Hold off requests during reset and in the cycle after it
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff   <= NEAR_RESET;
         far_ff    <= FAR_RESET;
         invf_ff   <= INVF_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NEAR_DISTANCE: near_ff   <= csr_write_data;
            CSR_FAR_DISTANCE:  far_ff    <= csr_write_data;
            CSR_INVERSE_FOCAL: invf_ff   <= csr_write_data;
            CSR_IMAGE_WIDTH:   width_ff  <= csr_write_data[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_write_data[SIZE_W-1:0];
            CSR_CLOUD_ENABLE:  enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Flip the row to top-down, wrapping to the coordinate width
   assign row_wide = 32'(height_ff) - 32'd1 - 32'(req_row_from_bottom);
   assign req_meta = {req_red, req_green, req_blue, req_column, row_wide[COORD_BITS-1:0]};

   dpc_front #(
      .DEPTH_FRAC_BITS (F),
      .META_W          (META_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .near_distance (near_ff),
      .far_distance  (far_ff),
      .in_valid      (accept),
      .in_raw        (req_depth_raw),
      .in_meta       (req_meta),
      .out_valid     (fr_valid),
      .out_flags     (fr_flags),
      .out_den       (fr_den),
      .out_rem       (fr_rem),
      .out_low       (fr_low),
      .out_meta      (fr_meta)
   );

   dpc_divider #(
      .DEN_W  (DEN_W),
      .META_W (META_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_flags  (fr_flags),
      .in_den    (fr_den),
      .in_rem    (fr_rem),
      .in_low    (fr_low),
      .in_meta   (fr_meta),
      .out_valid (dv_valid),
      .out_flags (dv_flags),
      .out_quot  (dv_quot),
      .out_meta  (dv_meta)
   );

   dpc_project #(
      .COORD_BITS (COORD_BITS)
   ) u_project (
      .clock             (clock),
      .reset             (reset),
      .inverse_focal     (invf_ff),
      .image_width       (width_ff),
      .image_height      (height_ff),
      .cloud_enable      (enable_ff),
      .in_valid          (dv_valid),
      .in_flags          (dv_flags),
      .in_quot           (dv_quot),
      .in_meta           (dv_meta),
      .rsp_valid         (rsp_valid),
      .rsp_depth_metres  (rsp_depth_metres),
      .rsp_depth_valid   (rsp_depth_valid),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_point_z       (rsp_point_z),
      .rsp_packed_colour (rsp_packed_colour),
      .rsp_point_valid   (rsp_point_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_column    (rsp_out_column)
   );

endmodule

`default_nettype wire

>>> rtl/dpc_checker.sv
`default_nettype none

module dpc_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       rsp_valid,
   input  logic [31:0]                rsp_depth_metres,
   input  logic                       rsp_depth_valid,
   input  logic signed [31:0]         rsp_point_x,
   input  logic signed [31:0]         rsp_point_y,
   input  logic [31:0]                rsp_point_z,
   input  logic [23:0]                rsp_packed_colour,
   input  logic                       rsp_point_valid
);

   localparam int LATENCY = 38;

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   // Every result traces back to an accepted transaction
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching transaction");

   // A valid point carries its depth as z
   a_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_valid |->
         rsp_depth_valid && rsp_depth_metres != 32'd0 && rsp_point_z == rsp_depth_metres)
      else $error("inconsistent valid point");

   // Invalid depth reads as zero
   a_invalid_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_depth_valid |-> rsp_depth_metres == 32'd0 && !rsp_point_valid)
      else $error("invalid depth not zeroed");

   // Invalid points are zeroed
   a_zero_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |->
         rsp_point_x == 32'sd0 && rsp_point_y == 32'sd0 && rsp_point_z == 32'd0 &&
         rsp_packed_colour == 24'd0)
      else $error("invalid point not zeroed");

endmodule

bind depth_to_point_cloud dpc_checker u_checker (.*);

`default_nettype wire
